/* design/periodic_timer_slot_scheduler_macros.svh */
// Assertion macros for the periodic timer slot scheduler
`ifndef PERIODIC_TIMER_SLOT_SCHEDULER_MACROS_SVH
`define PERIODIC_TIMER_SLOT_SCHEDULER_MACROS_SVH

`ifndef SYNTH
`define PTSS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define PTSS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define PTSS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define PTSS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

/* design/ptss_pkg.sv */
`default_nettype none
package ptss_pkg;

  localparam int NUM_SLOTS   = 8;
  localparam int SLOT_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int MAX_RESULTS = 8;
  localparam int FIRE_CNT_W  = $clog2(MAX_RESULTS + 1);
  localparam int CNT_W       = 16;
  localparam int HDL_W       = 16;
  localparam int ID_W        = 3;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic [1:0] REQ_TICK     = 2'd0;
  localparam logic [1:0] REQ_REGISTER = 2'd1;
  localparam logic [1:0] REQ_REMOVE   = 2'd2;

  localparam logic [1:0] KIND_REGISTERED = 2'd0;
  localparam logic [1:0] KIND_FULL       = 2'd1;
  localparam logic [1:0] KIND_FIRED      = 2'd2;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [7:0]       slot;
    logic [CNT_W-1:0] period;
    logic [HDL_W-1:0] handle;
  } req_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [ID_W-1:0]  slot_id;
    logic [HDL_W-1:0] fired_handle;
    logic             last;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RSCAN,
    ST_REMOVE,
    ST_TSCAN,
    ST_TDRAIN,
    ST_ESCAN,
    ST_EDRAIN
  } state_t;

  typedef struct packed {
    logic accept;
    logic idx_clr;
    logic idx_inc;
    logic reg_wr;
    logic full_ld;
    logic rem_wr;
    logic tick_rd;
    logic emit_rd;
  } ctrl_cmd_t;

  typedef struct packed {
    logic free;
    logic idx_last;
  } ctrl_sts_t;

endpackage
`default_nettype wire

/* design/ptss_ram.sv */
`default_nettype none
module ptss_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* design/ptss_ctrl.sv */
`default_nettype none
module ptss_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [1:0]            req_type,
  input  wire ptss_pkg::ctrl_sts_t   sts,
  output ptss_pkg::ctrl_cmd_t        cmd,
  output logic                       busy
);

  ptss_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ptss_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    unique case (state)
      ptss_pkg::ST_IDLE: begin
        busy        = 1'b0;
        cmd.idx_clr = 1'b1;
        if (start) begin
          cmd.accept = 1'b1;
          priority case (req_type)
            ptss_pkg::REQ_TICK:     state_next = ptss_pkg::ST_TSCAN;
            ptss_pkg::REQ_REGISTER: state_next = ptss_pkg::ST_RSCAN;
            ptss_pkg::REQ_REMOVE:   state_next = ptss_pkg::ST_REMOVE;
            default:                state_next = ptss_pkg::ST_IDLE;
          endcase
        end
      end
      ptss_pkg::ST_RSCAN: begin
        priority if (sts.free) begin
          cmd.reg_wr = 1'b1;
          state_next = ptss_pkg::ST_IDLE;
        end else if (sts.idx_last) begin
          cmd.full_ld = 1'b1;
          state_next  = ptss_pkg::ST_IDLE;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      ptss_pkg::ST_REMOVE: begin
        cmd.rem_wr = 1'b1;
        state_next = ptss_pkg::ST_IDLE;
      end
      ptss_pkg::ST_TSCAN: begin
        cmd.tick_rd = 1'b1;
        if (sts.idx_last) begin
          cmd.idx_clr = 1'b1;
          state_next  = ptss_pkg::ST_TDRAIN;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      ptss_pkg::ST_TDRAIN: begin
        state_next = ptss_pkg::ST_ESCAN;
      end
      ptss_pkg::ST_ESCAN: begin
        cmd.emit_rd = 1'b1;
        if (sts.idx_last) begin
          state_next = ptss_pkg::ST_EDRAIN;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      ptss_pkg::ST_EDRAIN: begin
        state_next = ptss_pkg::ST_IDLE;
      end
      default: begin
        state_next = ptss_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

/* design/ptss_datapath.sv */
`default_nettype none
`include "periodic_timer_slot_scheduler_macros.svh"
module ptss_datapath (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire ptss_pkg::req_t        req,
  input  wire ptss_pkg::ctrl_cmd_t   cmd,
  output ptss_pkg::ctrl_sts_t        sts,
  output logic                       res_strobe,
  output ptss_pkg::res_t             res
);

  localparam int N  = ptss_pkg::NUM_SLOTS;
  localparam int SW = ptss_pkg::SLOT_W;

  ptss_pkg::req_t rq;

  logic [SW-1:0] idx, idx_d;
  logic          tick_pend, emit_pend;
  logic [N-1:0]  active, per_vld, cnt_vld, fire;
  logic [ptss_pkg::FIRE_CNT_W-1:0] fire_cnt;
  logic          res_valid, res_valid_next;
  ptss_pkg::res_t res_next;

  logic [ptss_pkg::CNT_W-1:0] per_q, cnt_q, per_rd, cnt_rd, cnt_inc;
  logic [ptss_pkg::HDL_W-1:0] hdl_q;

  logic          rem_ok, due, fire_ok, emit_hit;
  logic [SW-1:0] rem_idx;
  logic [N-1:0]  fire_rest;

  logic                       per_we, cnt_we;
  logic [SW-1:0]              per_waddr, cnt_waddr;
  logic [ptss_pkg::CNT_W-1:0] per_wdata, cnt_wdata;

  assign rem_ok  = rq.slot < 8'(N);
  assign rem_idx = rq.slot[SW-1:0];

  assign per_rd  = per_vld[idx_d] ? per_q : '0;
  assign cnt_rd  = cnt_vld[idx_d] ? cnt_q : '0;
  assign cnt_inc = (cnt_rd == ptss_pkg::CNT_MAX) ? cnt_rd : cnt_rd + 1'b1;
  assign due     = active[idx_d] && (cnt_inc >= per_rd);
  assign fire_ok = tick_pend && due &&
                   (fire_cnt < ptss_pkg::FIRE_CNT_W'(ptss_pkg::MAX_RESULTS));
  assign emit_hit = emit_pend && fire[idx_d];

  always_comb begin
    fire_rest        = fire;
    fire_rest[idx_d] = 1'b0;
  end

  assign per_we    = cmd.reg_wr || (cmd.rem_wr && rem_ok);
  assign per_waddr = cmd.reg_wr ? idx : rem_idx;
  assign per_wdata = cmd.reg_wr ? rq.period : '0;

  assign cnt_we    = cmd.reg_wr || tick_pend;
  assign cnt_waddr = cmd.reg_wr ? idx : idx_d;
  assign cnt_wdata = (cmd.reg_wr || fire_ok) ? '0 : cnt_inc;

  ptss_ram #(.WIDTH(ptss_pkg::CNT_W), .DEPTH(N)) u_period_ram (
    .clk   (clk),
    .we    (per_we),
    .waddr (per_waddr),
    .wdata (per_wdata),
    .raddr (idx),
    .rdata (per_q)
  );

  ptss_ram #(.WIDTH(ptss_pkg::CNT_W), .DEPTH(N)) u_count_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (idx),
    .rdata (cnt_q)
  );

  ptss_ram #(.WIDTH(ptss_pkg::HDL_W), .DEPTH(N)) u_handle_ram (
    .clk   (clk),
    .we    (cmd.reg_wr),
    .waddr (idx),
    .wdata (rq.handle),
    .raddr (idx),
    .rdata (hdl_q)
  );

  always_comb begin
    res_valid_next = 1'b0;
    res_next       = res;
    priority if (cmd.reg_wr) begin
      res_valid_next        = 1'b1;
      res_next.kind         = ptss_pkg::KIND_REGISTERED;
      res_next.slot_id      = ptss_pkg::ID_W'(idx);
      res_next.fired_handle = '0;
      res_next.last         = 1'b1;
    end else if (cmd.full_ld) begin
      res_valid_next        = 1'b1;
      res_next.kind         = ptss_pkg::KIND_FULL;
      res_next.slot_id      = '0;
      res_next.fired_handle = '0;
      res_next.last         = 1'b1;
    end else if (emit_hit) begin
      res_valid_next        = 1'b1;
      res_next.kind         = ptss_pkg::KIND_FIRED;
      res_next.slot_id      = ptss_pkg::ID_W'(idx_d);
      res_next.fired_handle = hdl_q;
      res_next.last         = (fire_rest == '0);
    end else begin
      res_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rq <= req;
    end
    idx_d <= idx;
    res   <= res_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      tick_pend <= 1'b0;
      emit_pend <= 1'b0;
      active    <= '0;
      per_vld   <= '0;
      cnt_vld   <= '0;
      fire      <= '0;
      fire_cnt  <= '0;
      res_valid <= 1'b0;
    end else begin
      tick_pend <= cmd.tick_rd;
      emit_pend <= cmd.emit_rd;
      res_valid <= res_valid_next;
      priority if (cmd.idx_clr) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx + 1'b1;
      end
      if (cmd.accept) begin
        fire     <= '0;
        fire_cnt <= '0;
      end
      if (cmd.reg_wr) begin
        active[idx]  <= 1'b1;
        per_vld[idx] <= 1'b1;
        cnt_vld[idx] <= 1'b1;
      end
      if (cmd.rem_wr && rem_ok) begin
        active[rem_idx]  <= 1'b0;
        per_vld[rem_idx] <= 1'b1;
      end
      if (tick_pend) begin
        cnt_vld[idx_d] <= 1'b1;
      end
      if (fire_ok) begin
        fire[idx_d] <= 1'b1;
        fire_cnt    <= fire_cnt + 1'b1;
      end
      if (emit_hit) begin
        fire[idx_d] <= 1'b0;
      end
    end
  end

  assign sts.free     = !active[idx];
  assign sts.idx_last = (idx == SW'(N - 1));
  assign res_strobe   = res_valid;

  `PTSS_ASSERT_IMP(a_notlast_is_fire, clk, rst, res_valid && !res.last, res.kind == ptss_pkg::KIND_FIRED, "non-final item is not a fire")
  `PTSS_ASSERT_NXT(a_single_answer, clk, rst, res_valid && (res.kind != ptss_pkg::KIND_FIRED), !res_valid, "item follows a single answer")
  `PTSS_ASSERT_IMP(a_more_pending, clk, rst, res_valid && (res.kind == ptss_pkg::KIND_FIRED) && !res.last, fire != '0, "fire not last but none pending")
  `PTSS_ASSERT_IMP(a_fire_cap, clk, rst, tick_pend, fire_cnt <= ptss_pkg::FIRE_CNT_W'(ptss_pkg::MAX_RESULTS), "fire count above cap")

endmodule
`default_nettype wire

/* design/periodic_timer_slot_scheduler.sv */
// Tick: busy for one pass over the slot RAMs to age the counts, then one pass to
//   read handles; fire items come from the second pass.
// Register: busy while it scans for a free slot, item on res in the
//   cycle after the last scan step. Remove: writes the slot, no item.
// Results appear one per cycle on res for one cycle each; the receiver cannot stall.
// Reset (rst, synchronous): all slots free, periods and counts read as zero.
`default_nettype none
module periodic_timer_slot_scheduler (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire ptss_pkg::req_t   req,
  output logic                  busy,
  output logic                  res_strobe,
  output ptss_pkg::res_t        res
);

  ptss_pkg::ctrl_cmd_t cmd;
  ptss_pkg::ctrl_sts_t sts;

  ptss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req.req_type),
    .sts      (sts),
    .cmd      (cmd),
    .busy     (busy)
  );

  ptss_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .cmd        (cmd),
    .sts        (sts),
    .res_strobe (res_strobe),
    .res        (res)
  );

endmodule
`default_nettype wire

/* verif/periodic_timer_slot_scheduler_test.sv */
module periodic_timer_slot_scheduler_test;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 360;
  localparam int QUIET_LIMIT  = 1000;
  localparam int TAIL_CYCLES  = 40;

  typedef struct {
    ptss_pkg::req_t item;
    bit             hold;
    bit             steady;
  } pending_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  ptss_pkg::req_t req = '0;
  logic busy;
  logic res_strobe;
  ptss_pkg::res_t res;

  pending_t       request_q[$];
  ptss_pkg::res_t slot_events_q[$];

  logic                       slot_on  [ptss_pkg::NUM_SLOTS];
  logic [ptss_pkg::CNT_W-1:0] slot_per [ptss_pkg::NUM_SLOTS];
  logic [ptss_pkg::CNT_W-1:0] slot_cnt [ptss_pkg::NUM_SLOTS];
  logic [ptss_pkg::HDL_W-1:0] slot_hdl [ptss_pkg::NUM_SLOTS];

  logic took = 1'b0;
  int   quiet_cycles = 0;
  int   errors = 0;
  ptss_pkg::res_t want;

  periodic_timer_slot_scheduler u_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .req        (req),
    .busy       (busy),
    .res_strobe (res_strobe),
    .res        (res)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  task automatic enqueue_req(input logic [1:0] rtype, input logic [7:0] sl,
                             input logic [15:0] per, input logic [15:0] hd,
                             input bit hold, input bit steady);
    pending_t p;
    p.item.req_type = rtype;
    p.item.slot     = sl;
    p.item.period   = per;
    p.item.handle   = hd;
    p.hold          = hold;
    p.steady        = steady;
    request_q.push_back(p);
  endtask

  task automatic apply_request(input ptss_pkg::req_t r);
    ptss_pkg::res_t ev;
    ptss_pkg::res_t fires[$];
    bit   found;
    int   n;
    found = 1'b0;
    n = 0;
    ev = '0;
    case (r.req_type)
      ptss_pkg::REQ_REGISTER: begin
        for (int i = 0; i < ptss_pkg::NUM_SLOTS; i++) begin
          if (!found && !slot_on[i]) begin
            found       = 1'b1;
            slot_on[i]  = 1'b1;
            slot_per[i] = r.period;
            slot_hdl[i] = r.handle;
            slot_cnt[i] = '0;
            ev.kind     = ptss_pkg::KIND_REGISTERED;
            ev.slot_id  = i[ptss_pkg::ID_W-1:0];
          end
        end
        if (!found) begin
          ev.kind    = ptss_pkg::KIND_FULL;
          ev.slot_id = '0;
        end
        ev.fired_handle = '0;
        ev.last         = 1'b1;
        slot_events_q.push_back(ev);
      end
      ptss_pkg::REQ_REMOVE: begin
        if (r.slot < ptss_pkg::NUM_SLOTS) begin
          slot_on[r.slot[ptss_pkg::SLOT_W-1:0]]  = 1'b0;
          slot_per[r.slot[ptss_pkg::SLOT_W-1:0]] = '0;
        end
      end
      ptss_pkg::REQ_TICK: begin
        for (int i = 0; i < ptss_pkg::NUM_SLOTS; i++) begin
          if (slot_cnt[i] != ptss_pkg::CNT_MAX) slot_cnt[i] = slot_cnt[i] + 1'b1;
        end
        for (int i = 0; i < ptss_pkg::NUM_SLOTS; i++) begin
          if (n < ptss_pkg::MAX_RESULTS && slot_on[i] && slot_cnt[i] >= slot_per[i]) begin
            slot_cnt[i]     = '0;
            ev.kind         = ptss_pkg::KIND_FIRED;
            ev.slot_id      = i[ptss_pkg::ID_W-1:0];
            ev.fired_handle = slot_hdl[i];
            ev.last         = 1'b0;
            fires.push_back(ev);
            n++;
          end
        end
        if (n > 0) begin
          ev = fires.pop_back();
          ev.last = 1'b1;
          fires.push_back(ev);
        end
        foreach (fires[k]) slot_events_q.push_back(fires[k]);
      end
      default: ;
    endcase
  endtask

  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !took) begin
    end else if (request_q.size() == 0) begin
      start <= 1'b0;
    end else if (request_q[0].hold && (slot_events_q.size() != 0 || busy)) begin
      start <= 1'b0;
    end else if (!request_q[0].steady && $urandom_range(0, 99) < 25) begin
      start <= 1'b0;
    end else begin
      start <= 1'b1;
      req   <= request_q[0].item;
      void'(request_q.pop_front());
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ptss_pkg::NUM_SLOTS; i++) begin
        slot_on[i]  = 1'b0;
        slot_per[i] = '0;
        slot_cnt[i] = '0;
        slot_hdl[i] = '0;
      end
      slot_events_q.delete();
      took         <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      took <= start && !busy;
      if (res_strobe) begin
        if (slot_events_q.size() == 0) begin
          $display("%0t: unexpected result kind %0d slot_id %0d handle %h last %0d",
                   $time, res.kind, res.slot_id, res.fired_handle, res.last);
          errors++;
        end else begin
          want = slot_events_q.pop_front();
          if (res.kind !== want.kind) begin
            $display("%0t: kind expected %0d got %0d", $time, want.kind, res.kind);
            errors++;
          end
          if (res.slot_id !== want.slot_id) begin
            $display("%0t: slot_id expected %0d got %0d", $time, want.slot_id, res.slot_id);
            errors++;
          end
          if (res.fired_handle !== want.fired_handle) begin
            $display("%0t: fired_handle expected %h got %h", $time, want.fired_handle,
                     res.fired_handle);
            errors++;
          end
          if (res.last !== want.last) begin
            $display("%0t: last expected %0d got %0d", $time, want.last, res.last);
            errors++;
          end
        end
      end
      if (start && !busy) apply_request(req);
      quiet_cycles <= (start && !busy) ? 0 : quiet_cycles + 1;
    end
  end

  initial begin
    int         roll;
    int         counted;
    bit         ignored;
    bit         timed_out;
    logic [1:0] rtype;
    logic [7:0] sl;
    logic [15:0] per;
    timed_out = 1'b0;

    enqueue_req(ptss_pkg::REQ_TICK,     8'd0,   16'h0000, 16'h0000, 1'b0, 1'b0);
    enqueue_req(ptss_pkg::REQ_REGISTER, 8'd0,   16'h0000, 16'hFFFF, 1'b0, 1'b0);
    enqueue_req(ptss_pkg::REQ_TICK,     8'd0,   16'h0000, 16'h0000, 1'b0, 1'b0);
    enqueue_req(ptss_pkg::REQ_REGISTER, 8'hFF,  16'hFFFF, 16'h0000, 1'b0, 1'b0);
    enqueue_req(ptss_pkg::REQ_REGISTER, 8'd0,   16'h0001, 16'hA5A5, 1'b0, 1'b0);
    enqueue_req(ptss_pkg::REQ_REGISTER, 8'd0,   16'h0002, 16'h5A5A, 1'b0, 1'b0);
    enqueue_req(ptss_pkg::REQ_REGISTER, 8'd0,   16'h0003, 16'h0001, 1'b0, 1'b0);
    enqueue_req(ptss_pkg::REQ_REGISTER, 8'd0,   16'h0000, 16'h8000, 1'b0, 1'b0);
    enqueue_req(ptss_pkg::REQ_REGISTER, 8'd0,   16'h0001, 16'h1234, 1'b0, 1'b0);
    enqueue_req(ptss_pkg::REQ_REGISTER, 8'd0,   16'h0005, 16'hFEDC, 1'b0, 1'b0);
    enqueue_req(ptss_pkg::REQ_REGISTER, 8'd0,   16'h0007, 16'h4321, 1'b0, 1'b0);
    enqueue_req(ptss_pkg::REQ_TICK,     8'hFF,  16'hFFFF, 16'hFFFF, 1'b0, 1'b0);
    enqueue_req(ptss_pkg::REQ_TICK,     8'd0,   16'h0000, 16'h0000, 1'b0, 1'b0);
    enqueue_req(ptss_pkg::REQ_TICK,     8'd0,   16'h0000, 16'h0000, 1'b0, 1'b0);
    enqueue_req(ptss_pkg::REQ_REMOVE,   8'hFF,  16'h0000, 16'h0000, 1'b0, 1'b0);
    enqueue_req(ptss_pkg::REQ_REMOVE,   8'd8,   16'h0000, 16'h0000, 1'b0, 1'b0);
    enqueue_req(REQ_UNUSED,             8'd0,   16'hFFFF, 16'hFFFF, 1'b0, 1'b0);
    enqueue_req(ptss_pkg::REQ_REMOVE,   8'd7,   16'hFFFF, 16'hFFFF, 1'b0, 1'b0);
    enqueue_req(ptss_pkg::REQ_REMOVE,   8'd7,   16'h0000, 16'h0000, 1'b0, 1'b0);
    enqueue_req(ptss_pkg::REQ_REGISTER, 8'd0,   16'h0000, 16'h7777, 1'b0, 1'b0);
    enqueue_req(ptss_pkg::REQ_REMOVE,   8'd0,   16'h0000, 16'h0000, 1'b0, 1'b0);
    enqueue_req(ptss_pkg::REQ_REGISTER, 8'd0,   16'h0004, 16'hCAFE, 1'b0, 1'b0);
    enqueue_req(ptss_pkg::REQ_TICK,     8'd0,   16'h0000, 16'h0000, 1'b0, 1'b0);
    enqueue_req(ptss_pkg::REQ_TICK,     8'd0,   16'h0000, 16'h0000, 1'b0, 1'b0);

    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      roll = $urandom_range(0, 99);
      sl   = 8'($urandom);
      per  = 16'($urandom);
      if (roll < 48) begin
        rtype = ptss_pkg::REQ_TICK;
      end else if (roll < 70) begin
        rtype = ptss_pkg::REQ_REGISTER;
        if ($urandom_range(0, 9) != 0) per = 16'($urandom_range(0, 6));
      end else if (roll < 94) begin
        rtype = ptss_pkg::REQ_REMOVE;
        sl = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(ptss_pkg::NUM_SLOTS, 255))
                                         : 8'($urandom_range(0, ptss_pkg::NUM_SLOTS - 1));
      end else begin
        rtype = REQ_UNUSED;
      end
      ignored = (rtype == REQ_UNUSED) ||
                (rtype == ptss_pkg::REQ_REMOVE && sl >= ptss_pkg::NUM_SLOTS);
      enqueue_req(rtype, sl, per, 16'($urandom),
                  !ignored && (counted == 150 || counted == 300),
                  counted >= 200 && counted < 280);
      if (!ignored) counted++;
    end

    repeat (8) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (!timed_out && (request_q.size() != 0 || start)) begin
      @(posedge clk);
      if (quiet_cycles >= QUIET_LIMIT) timed_out = 1'b1;
    end
    while (!timed_out && slot_events_q.size() != 0) begin
      @(posedge clk);
      if (quiet_cycles >= QUIET_LIMIT) timed_out = 1'b1;
    end
    if (!timed_out) repeat (TAIL_CYCLES) @(posedge clk);

    if (!timed_out && errors == 0 && slot_events_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
